[sv/gndf_pkg.sv]
`default_nettype none
package gndf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 64;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_VEL      = 3'd1,
    MODE_MASS_VEL = 3'd2,
    MODE_VISCO    = 3'd3,
    MODE_SQRT     = 3'd4
  } damp_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 2'd0,
    REG_COEF = 2'd1
  } cfg_reg_t;

  // per-item data that rides alongside the divider and root pipes
  typedef struct packed {
    logic              valid;
    logic              vneg;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] pre;
    logic              sat;
    logic              root_ok;
  } side_t;

endpackage
`default_nettype wire

[sv/granular_normal_damping_force.sv]
// throughput: one request per cycle while the output is not stalled;
// the 64-stage divider and the root pipe set the depth
// a stalled output holds the whole pipeline, nothing is dropped
// reset (rst_n low, synchronous) clears all valid bits, mode to none and coefficient to zero
`default_nettype none
module granular_normal_damping_force
  import gndf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [DATA_W-1:0]           cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [DATA_W-1:0]    in_normal_velocity,
  input  wire logic [DATA_W-1:0]           in_effective_mass,
  input  wire logic [DATA_W-1:0]           in_contact_radius,
  input  wire logic signed [DATA_W-1:0]    in_overlap,
  input  wire logic signed [DATA_W-1:0]    in_normal_force,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [DATA_W-1:0]         out_damping_force,
  output logic [DATA_W-1:0]                out_prefactor,
  output logic                             out_saturated
);

  localparam int RAD_W  = PROD_W + FRAC_BITS;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int T_W    = PROD_W - FRAC_BITS;
  localparam int F3_W   = T_W + DATA_W;
  localparam int M4_W   = DATA_W + ROOT_W;
  localparam int SIDE_D = PROD_W + ROOT_W - 2;

  damp_mode_t        mode_r;
  logic [DATA_W-1:0] coef_r;
  logic              en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
      coef_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE: mode_r <= damp_mode_t'(cfg_data[2:0]);
        REG_COEF: coef_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: input capture
  logic              v0_r;
  logic [DATA_W-1:0] vel0_r, mass0_r, rad0_r, ovl0_r, frc0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel0_r  <= $unsigned(in_normal_velocity);
      mass0_r <= in_effective_mass;
      rad0_r  <= in_contact_radius;
      ovl0_r  <= $unsigned(in_overlap);
      frc0_r  <= $unsigned(in_normal_force);
    end
  end

  // stage 1: coefficient times mass, mass times force
  logic              v1_r, vneg1_r, ok1_r;
  logic [PROD_W-1:0] pcm1_r, pmf1_r;
  logic [DATA_W-1:0] mag1_r, rad1_r, ovl1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcm1_r  <= PROD_W'(coef_r) * PROD_W'(mass0_r);
      pmf1_r  <= PROD_W'(mass0_r) * PROD_W'(frc0_r);
      vneg1_r <= vel0_r[DATA_W-1];
      mag1_r  <= vel0_r[DATA_W-1] ? DATA_W'(-vel0_r) : vel0_r;
      ok1_r   <= (ovl0_r != '0) && !ovl0_r[DATA_W-1] &&
                 (frc0_r != '0) && !frc0_r[DATA_W-1];
      rad1_r  <= rad0_r;
      ovl1_r  <= ovl0_r;
    end
  end

  // stage 2: truncated c*m times radius, split in two partial products
  logic              v2_r, vneg2_r, ok2_r;
  logic [PROD_W-1:0] pcm2_r, plo2_r;
  logic [T_W-1:0]    phi2_r;
  logic [DATA_W-1:0] mag2_r;
  logic [T_W-1:0]    t1;

  assign t1 = pcm1_r[PROD_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo2_r  <= PROD_W'(t1[DATA_W-1:0]) * PROD_W'(rad1_r);
      phi2_r  <= T_W'(T_W'(t1[T_W-1:DATA_W]) * T_W'(rad1_r));
      pcm2_r  <= pcm1_r;
      vneg2_r <= vneg1_r;
      mag2_r  <= mag1_r;
      ok2_r   <= ok1_r;
    end
  end

  // stage 3: prefactor for the modes without a root
  logic [F3_W-1:0]   full3;
  logic              sat2, sat3;
  side_t             side3;

  assign full3 = (F3_W'(phi2_r) << DATA_W) + F3_W'(plo2_r);
  assign sat2  = |pcm2_r[PROD_W-1:DATA_W+FRAC_BITS];
  assign sat3  = |full3[F3_W-1:DATA_W+FRAC_BITS];

  always_comb begin
    side3         = '0;
    side3.valid   = v2_r;
    side3.vneg    = vneg2_r;
    side3.mag     = mag2_r;
    side3.root_ok = ok2_r;
    case (mode_r)
      MODE_VEL: side3.pre = coef_r;
      MODE_MASS_VEL: begin
        side3.pre = sat2 ? '1 : pcm2_r[DATA_W+FRAC_BITS-1:FRAC_BITS];
        side3.sat = sat2;
      end
      MODE_VISCO: begin
        side3.pre = sat3 ? '1 : full3[DATA_W+FRAC_BITS-1:FRAC_BITS];
        side3.sat = sat3;
      end
      default: side3.pre = '0;
    endcase
  end

  side_t side_r [SIDE_D+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= SIDE_D; i++) side_r[i] <= '0;
    end else if (en) begin
      side_r[0] <= side3;
      for (int i = 1; i <= SIDE_D; i++) side_r[i] <= side_r[i-1];
    end
  end

  // floor(m*f/d), then floor(sqrt(q << FRAC_BITS))
  logic [PROD_W-1:0] quo;
  logic [RAD_W-1:0]  rad_x;
  logic [ROOT_W-1:0] root;

  gndf_div_pipe #(
    .NUM_W (PROD_W),
    .DEN_W (DATA_W)
  ) u_div (
    .clk (clk),
    .en  (en),
    .num (pmf1_r),
    .den (ovl1_r),
    .quo (quo)
  );

  assign rad_x = RAD_W'(quo) << FRAC_BITS;

  gndf_sqrt_pipe #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  ((2*ROOT_W)'(rad_x)),
    .root (root)
  );

  // m1: coefficient times root, split
  side_t               m1_r;
  logic [PROD_W-1:0]   mlo1_r;
  logic [ROOT_W-1:0]   mhi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_r <= '0;
    else if (en) m1_r <= side_r[SIDE_D];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mlo1_r <= PROD_W'(coef_r) * PROD_W'(root[DATA_W-1:0]);
      mhi1_r <= ROOT_W'(ROOT_W'(coef_r) * ROOT_W'(root[ROOT_W-1:DATA_W]));
    end
  end

  // m2: final prefactor
  logic [M4_W-1:0] full4;
  logic            sat4;
  side_t           m2_nxt, m2_r;

  assign full4 = (M4_W'(mhi1_r) << DATA_W) + M4_W'(mlo1_r);
  assign sat4  = |full4[M4_W-1:DATA_W+FRAC_BITS];

  always_comb begin
    m2_nxt = m1_r;
    if (mode_r == MODE_SQRT) begin
      if (m1_r.root_ok) begin
        m2_nxt.pre = sat4 ? '1 : full4[DATA_W+FRAC_BITS-1:FRAC_BITS];
        m2_nxt.sat = sat4;
      end else begin
        m2_nxt.pre = '0;
        m2_nxt.sat = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m2_r <= '0;
    else if (en) m2_r <= m2_nxt;
  end

  // m3: prefactor times speed magnitude
  side_t             m3_r;
  logic [PROD_W-1:0] prod3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m3_r <= '0;
    else if (en) m3_r <= m2_r;
  end

  always_ff @(posedge clk) begin
    if (en) prod3_r <= PROD_W'(m2_r.pre) * PROD_W'(m2_r.mag);
  end

  // m4: shift, clip and sign
  logic [T_W-1:0]    res;
  logic [DATA_W-1:0] force_nxt;
  logic              sat_nxt;
  logic              out_valid_r, out_sat_r;
  logic [DATA_W-1:0] out_force_r, out_pre_r;

  assign res = prod3_r[PROD_W-1:FRAC_BITS];

  always_comb begin
    sat_nxt = m3_r.sat;
    if (m3_r.vneg) begin
      if (res > T_W'(32'h7FFF_FFFF)) begin
        force_nxt = 32'h7FFF_FFFF;
        sat_nxt   = 1'b1;
      end else begin
        force_nxt = res[DATA_W-1:0];
      end
    end else begin
      if (res > T_W'(32'h8000_0000)) begin
        force_nxt = 32'h8000_0000;
        sat_nxt   = 1'b1;
      end else begin
        force_nxt = DATA_W'(-res[DATA_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= m3_r.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_force_r <= force_nxt;
      out_pre_r   <= m3_r.pre;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_damping_force = $signed(out_force_r);
  assign out_prefactor     = out_pre_r;
  assign out_saturated     = out_sat_r;

endmodule
`default_nettype wire

[sv/gndf_div_pipe.sv]
`default_nettype none
module gndf_div_pipe
  import gndf_pkg::*;
#(
  parameter int NUM_W = PROD_W,
  parameter int DEN_W = DATA_W
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo
);

  // restoring division, one quotient bit per stage
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] sh_r  [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_src;
    logic [NUM_W-1:0] sh_src;
    logic [DEN_W-1:0] den_src;
    logic [DEN_W:0]   tmp;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_src = '0;
      assign sh_src  = num;
      assign den_src = den;
    end else begin : g_next
      assign rem_src = rem_r[k-1];
      assign sh_src  = sh_r[k-1];
      assign den_src = den_r[k-1];
    end

    assign tmp = {rem_src, sh_src[NUM_W-1]};
    assign ge  = tmp >= {1'b0, den_src};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DEN_W'(tmp - {1'b0, den_src}) : tmp[DEN_W-1:0];
        sh_r[k]  <= {sh_src[NUM_W-2:0], ge};
        den_r[k] <= den_src;
      end
    end
  end

  assign quo = sh_r[NUM_W-1];

endmodule
`default_nettype wire

[sv/gndf_sqrt_pipe.sv]
`default_nettype none
module gndf_sqrt_pipe
  import gndf_pkg::*;
#(
  parameter int ROOT_W = 40
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [2*ROOT_W-1:0] rad,
  output logic      [ROOT_W-1:0]   root
);

  localparam int REM_W = ROOT_W + 2;

  // digit-by-digit square root, one root bit per stage
  logic [REM_W-1:0]    rem_r  [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [2*ROOT_W-1:0] x_r    [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0]    rem_src;
    logic [ROOT_W-1:0]   root_src;
    logic [2*ROOT_W-1:0] x_src;
    logic [REM_W+1:0]    tmp;
    logic [REM_W+1:0]    trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_src  = '0;
      assign root_src = '0;
      assign x_src    = rad;
    end else begin : g_next
      assign rem_src  = rem_r[k-1];
      assign root_src = root_r[k-1];
      assign x_src    = x_r[k-1];
    end

    assign tmp   = {rem_src, x_src[2*ROOT_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_src, 2'b01});
    assign ge    = tmp >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? REM_W'(tmp - trial) : tmp[REM_W-1:0];
        root_r[k] <= {root_src[ROOT_W-2:0], ge};
        x_r[k]    <= {x_src[2*ROOT_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule
`default_nettype wire

[sv/gndf_checker.sv]
`default_nettype none
module gndf_checker
  import gndf_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [DATA_W-1:0] out_damping_force,
  input wire logic [DATA_W-1:0]        out_prefactor,
  input wire logic                     out_saturated
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_damping_force) &&
      $stable(out_prefactor) && $stable(out_saturated))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // pipeline moves whenever the output slot is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free output");

  a_zero_pre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prefactor == '0 |-> out_damping_force == '0 && !out_saturated)
    else $error("nonzero force with zero prefactor");

endmodule

bind granular_normal_damping_force gndf_checker u_gndf_checker (.*);
`default_nettype wire

[sim/granular_normal_damping_force_tb.sv]
`default_nettype none
module granular_normal_damping_force_tb;
  import gndf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 140;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 400;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_3 = 2'd3;
  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [31:0] damping_force;
    logic [31:0] prefactor;
    logic        saturated;
  } damp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] in_normal_velocity = '0;
  logic [DATA_W-1:0] in_effective_mass = '0;
  logic [DATA_W-1:0] in_contact_radius = '0;
  logic signed [DATA_W-1:0] in_overlap = '0;
  logic signed [DATA_W-1:0] in_normal_force = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_damping_force;
  logic [DATA_W-1:0] out_prefactor;
  logic out_saturated;

  granular_normal_damping_force dut (.*);

  always #1 clk = ~clk;

  logic [2:0] mode_reg = MODE_NONE;
  logic [31:0] coef_reg = '0;
  damp_result_t force_q[$];
  int errors = 0;
  bit quiet = 0;
  bit hold_req = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] fix_mul_clip(input logic [63:0] a, input logic [63:0] b,
                                               inout bit sat);
    logic [63:0] lim;
    lim = (64'd1 << (32 + FB)) - 64'd1;
    if (a == 0 || b == 0) return 64'd0;
    if (a > lim / b) begin
      sat = 1;
      return 64'hFFFF_FFFF;
    end
    return (a * b) >> FB;
  endfunction

  function automatic damp_result_t predict_damping(input logic [31:0] vel, mass, rad, ovl, frc);
    logic [63:0] pre, mag, prod, res, q, rem, root, trial, c;
    logic [127:0] radicand;
    bit sat;
    damp_result_t r;
    c = 64'(coef_reg);
    sat = 0;
    pre = 0;
    case (mode_reg)
      MODE_VEL: pre = c;
      MODE_MASS_VEL: pre = fix_mul_clip(c, 64'(mass), sat);
      MODE_VISCO: pre = fix_mul_clip((c * 64'(mass)) >> FB, 64'(rad), sat);
      MODE_SQRT: begin
        if (!ovl[31] && ovl != 0 && !frc[31] && frc != 0) begin
          q = (64'(mass) * 64'(frc)) / 64'(ovl);
          radicand = {64'd0, q} << FB;
          rem = 0;
          root = 0;
          for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | 64'(radicand[2*i +: 2]);
            trial = (root << 2) | 64'd1;
            root = root << 1;
            if (rem >= trial) begin
              rem = rem - trial;
              root = root | 64'd1;
            end
          end
          pre = fix_mul_clip(c, root, sat);
        end
      end
      default: pre = 0;
    endcase
    mag = vel[31] ? ((64'd1 << 32) - 64'(vel)) : 64'(vel);
    prod = pre * mag;
    res = prod >> FB;
    if (vel[31]) begin
      if (res > 64'h7FFF_FFFF) begin
        res = 64'h7FFF_FFFF;
        sat = 1;
      end
    end else begin
      if (res > 64'h8000_0000) begin
        res = 64'h8000_0000;
        sat = 1;
      end
      res = ((64'd1 << 32) - res) & 64'hFFFF_FFFF;
    end
    r.damping_force = res[31:0];
    r.prefactor = pre[31:0];
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'd1;
      5, 6: return $urandom_range(0, 32'h3_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // called at a rising edge; leaves in_valid high when no gap follows
  task automatic send_contact(input logic [31:0] vel, mass, rad, ovl, frc);
    int gap;
    in_valid <= 1'b1;
    in_normal_velocity <= vel;
    in_effective_mass <= mass;
    in_contact_radius <= rad;
    in_overlap <= ovl;
    in_normal_force <= frc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    force_q.push_back(predict_damping(vel, mass, rad, ovl, frc));
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (force_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MODE) mode_reg = data[2:0];
    else if (idx == REG_COEF) coef_reg = data;
    @(posedge clk);
  endtask

  task automatic set_damping(input logic [2:0] mode, input logic [31:0] coef);
    drain();
    write_reg(REG_MODE, {$urandom} & 32'hFFFF_FFF8 | 32'(mode));
    write_reg(REG_COEF, coef);
  endtask

  task automatic send_random(input int n, input bit sqrt_bias);
    logic [31:0] ovl, frc;
    repeat (n) begin
      ovl = rand_word();
      frc = rand_word();
      if (sqrt_bias && $urandom_range(0, 3) != 0) begin
        ovl = $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
        if (ovl == 0) ovl = 1;
        frc = $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
        if (frc == 0) frc = 1;
      end
      send_contact(rand_word(), rand_word(), rand_word(), ovl, frc);
    end
  endtask

  task automatic test_directed();
    logic [2:0] modes[5] = '{MODE_NONE, MODE_VEL, MODE_MASS_VEL, MODE_VISCO, MODE_SQRT};
    // reset state first: mode none
    send_contact(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    write_reg(IDX_SPARE_2, 32'hFFFF_FFFF);
    write_reg(IDX_SPARE_3, 32'h0000_0003);
    foreach (modes[k]) begin
      set_damping(modes[k], (k % 2) ? 32'hFFFF_FFFF : 32'h0001_8000);
      send_contact(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_contact(32'h7FFF_FFFF, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0004_0000);
      send_contact(32'hFFFF_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_0000, 32'h0001_0000);
      send_contact(32'h0000_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000);
    end
    // sqrt mode with non-positive force, then exact square
    send_contact(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0);
    send_contact(32'h0001_0000, 32'h0004_0000, 32'h0, 32'h0001_0000, 32'h0001_0000);
  endtask

  task automatic test_mode_sweep();
    logic [2:0] modes[8] = '{MODE_NONE, MODE_VEL, MODE_MASS_VEL, MODE_VISCO, MODE_SQRT,
                             MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7};
    logic [31:0] coef;
    foreach (modes[k]) begin
      for (int j = 0; j < 3; j++) begin
        coef = (j == 0) ? 32'h0 : (j == 1) ? 32'hFFFF_FFFF : rand_word();
        if (j == 2 && modes[k] == MODE_SQRT) coef = $urandom_range(0, 32'h4_0000);
        set_damping(modes[k], coef);
        send_random((modes[k] > MODE_SQRT) ? 20 : 55, modes[k] == MODE_SQRT);
      end
    end
  endtask

  task automatic test_backpressure();
    set_damping(MODE_MASS_VEL, $urandom_range(1, 32'h2_0000));
    hold_req = 1;
    send_random(250, 0);
    // sender waits for every result before going on
    drain();
    set_damping(MODE_SQRT, $urandom_range(1, 32'h2_0000));
    send_random(40, 1);
  endtask

  task automatic test_full_rate();
    set_damping(MODE_VISCO, $urandom_range(1, 32'h2_0000));
    quiet = 1;
    send_random(80, 0);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_mode_sweep();
    test_backpressure();
    test_full_rate();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // result side stalls
  initial begin
    forever begin
      out_ready <= 1'b1;
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    damp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (force_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result force %h prefactor %h sat %b", $time,
                 out_damping_force, out_prefactor, out_saturated);
      end else begin
        want = force_q.pop_front();
        if (out_damping_force !== want.damping_force) begin
          errors++;
          $display("%0t damping_force expected %h actual %h", $time, want.damping_force,
                   out_damping_force);
        end
        if (out_prefactor !== want.prefactor) begin
          errors++;
          $display("%0t prefactor expected %h actual %h", $time, want.prefactor,
                   out_prefactor);
        end
        if (out_saturated !== want.saturated) begin
          errors++;
          $display("%0t saturated expected %b actual %b", $time, want.saturated,
                   out_saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
`default_nettype wire

[filelist.f]
sv/gndf_pkg.sv
sv/gndf_div_pipe.sv
sv/gndf_sqrt_pipe.sv
sv/granular_normal_damping_force.sv
sv/gndf_checker.sv
sim/granular_normal_damping_force_tb.sv
